FILE: rtl/lgr_pkg.sv
package lgr_pkg;

  localparam int CELLS_W     = 64;
  localparam int ROW_NUM_W   = 12;
  localparam int WIDTH_W     = 7;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(64);

  typedef struct packed {
    logic [CELLS_W-1:0]   next_cells;
    logic [ROW_NUM_W-1:0] row_number;
    logic                 frame_done;
  } result_t;

  typedef struct packed {
    logic upper;
    logic lower;
  } push_t;

endpackage

FILE: rtl/lgr_if.sv
interface lgr_in_if;
  import lgr_pkg::*;
  logic               valid;
  logic               ready;
  logic [CELLS_W-1:0] row_cells;
  logic               final_row;
  modport source (output valid, output row_cells, output final_row, input ready);
  modport sink   (input valid, input row_cells, input final_row, output ready);
endinterface

interface lgr_out_if;
  import lgr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CELLS_W-1:0]   next_cells;
  logic [ROW_NUM_W-1:0] row_number;
  logic                 frame_done;
  modport source (output valid, output next_cells, output row_number, output frame_done,
                  input ready);
  modport sink   (input valid, input next_cells, input row_number, input frame_done,
                  output ready);
endinterface

interface lgr_cfg_if;
  import lgr_pkg::*;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lgr_cell_lane.sv
module lgr_cell_lane (
  input  logic       en,
  input  logic [2:0] above,
  input  logic [2:0] middle,
  input  logic [2:0] below,
  output logic       alive
);
  logic [3:0] n;

  always_comb begin
    n = 4'(above[0]) + 4'(above[1]) + 4'(above[2])
      + 4'(middle[0]) + 4'(middle[2])
      + 4'(below[0]) + 4'(below[1]) + 4'(below[2]);
    alive = en & ((n == 4'd3) | ((n == 4'd2) & middle[1]));
  end
endmodule

FILE: rtl/lgr_result_queue.sv
module lgr_result_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  lgr_pkg::push_t   push,
  input  lgr_pkg::result_t ent_upper,
  input  lgr_pkg::result_t ent_lower,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output lgr_pkg::result_t out_data
);
  import lgr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  result_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt, wr_alt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [1:0]         n_push;
  logic               pop;

  always_comb begin
    n_push     = {1'b0, push.upper} + {1'b0, push.lower};
    pop        = out_valid & out_ready;
    wr_alt     = wr_ptr_r + PTR_W'(1);
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop);
    room       = count_r <= CNT_W'(QUEUE_DEPTH - 2);
    out_valid  = count_r != '0;
    out_data   = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (push.upper) begin
      mem_r[wr_ptr_r] <= ent_upper;
    end
    if (push.lower) begin
      mem_r[push.upper ? wr_alt : wr_ptr_r] <= ent_lower;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (push.upper || push.lower) |-> room)
    else $error("push without room");
endmodule

FILE: rtl/life_generation_row_engine.sv
// A result row is offered on out_ch from the result queue after its row beat is accepted.
// Throughput: one row beat per cycle while in_ch.ready is high; a final row releases
//   up to two results, which leave in order from a four-entry result queue.
// Input ready drops while fewer than two queue entries are free.
// Reset (rst_n low, synchronous): row history, row index and queue clear; width returns to 64.
module life_generation_row_engine #(
  parameter int GRID_WIDTH = 64,
  parameter int MAX_ROWS   = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  lgr_in_if.sink    in_ch,
  lgr_out_if.source out_ch,
  lgr_cfg_if.sink   cfg_ch
);
  import lgr_pkg::*;

  localparam int                   ROW_CAP_I = (MAX_ROWS - 1 < 4095) ? MAX_ROWS - 1 : 4095;
  localparam logic [ROW_NUM_W-1:0] ROW_CAP   = ROW_NUM_W'(ROW_CAP_I);
  localparam logic [WIDTH_W-1:0]   GRID_W    = WIDTH_W'(GRID_WIDTH);

  logic [WIDTH_W-1:0]    width_r, width_eff;
  logic [GRID_WIDTH-1:0] upper_r, middle_r, upper_nxt, middle_nxt;
  logic [ROW_NUM_W-1:0]  rows_r, rows_nxt, rows_inc;
  logic                  held_r, held_nxt;

  logic [GRID_WIDTH-1:0] mask, row_m, upper_m, mid_m, res_upper, res_lower;
  logic [GRID_WIDTH+1:0] up_pad, mid_pad, row_pad;
  logic                  in_fire, room;
  push_t                 push;
  result_t               ent_upper, ent_lower, out_data;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_ch.valid) begin
      width_r <= cfg_ch.data;
    end
  end

  always_comb begin
    width_eff = (width_r > GRID_W) ? GRID_W : width_r;
    for (int j = 0; j < GRID_WIDTH; j++) begin
      mask[j] = WIDTH_W'(j) < width_eff;
    end
    row_m   = in_ch.row_cells[GRID_WIDTH-1:0] & mask;
    upper_m = upper_r & mask;
    mid_m   = middle_r & mask;
    up_pad  = {1'b0, upper_m, 1'b0};
    mid_pad = {1'b0, mid_m, 1'b0};
    row_pad = {1'b0, row_m, 1'b0};
  end

  for (genvar j = 0; j < GRID_WIDTH; j++) begin : g_lane
    lgr_cell_lane u_upper (
      .en     (mask[j]),
      .above  (up_pad[j+2:j]),
      .middle (mid_pad[j+2:j]),
      .below  (row_pad[j+2:j]),
      .alive  (res_upper[j])
    );
    lgr_cell_lane u_lower (
      .en     (mask[j]),
      .above  (mid_pad[j+2:j]),
      .middle (row_pad[j+2:j]),
      .below  (3'b000),
      .alive  (res_lower[j])
    );
  end

  always_comb begin
    in_fire  = in_ch.valid & in_ch.ready;
    rows_inc = (rows_r < ROW_CAP) ? rows_r + ROW_NUM_W'(1) : ROW_CAP;

    push.upper = in_fire & held_r;
    push.lower = in_fire & in_ch.final_row;

    ent_upper.next_cells = CELLS_W'(res_upper);
    ent_upper.row_number = rows_r;
    ent_upper.frame_done = 1'b0;
    ent_lower.next_cells = CELLS_W'(res_lower);
    ent_lower.row_number = held_r ? rows_inc : '0;
    ent_lower.frame_done = 1'b1;

    upper_nxt  = upper_r;
    middle_nxt = middle_r;
    rows_nxt   = rows_r;
    held_nxt   = held_r;
    if (in_fire) begin
      if (in_ch.final_row) begin
        upper_nxt  = '0;
        middle_nxt = '0;
        rows_nxt   = '0;
        held_nxt   = 1'b0;
      end else begin
        upper_nxt  = held_r ? middle_r : '0;
        middle_nxt = row_m;
        rows_nxt   = held_r ? rows_inc : '0;
        held_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_r  <= '0;
      middle_r <= '0;
      rows_r   <= '0;
      held_r   <= 1'b0;
    end else begin
      upper_r  <= upper_nxt;
      middle_r <= middle_nxt;
      rows_r   <= rows_nxt;
      held_r   <= held_nxt;
    end
  end

  lgr_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .ent_upper (ent_upper),
    .ent_lower (ent_lower),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign in_ch.ready       = room;
  assign out_ch.next_cells = out_data.next_cells;
  assign out_ch.row_number = out_data.row_number;
  assign out_ch.frame_done = out_data.frame_done;

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.final_row) |=> (!held_r && rows_r == '0 && middle_r == '0))
    else $error("final row did not end the frame");

  a_row_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_ch.final_row) |=> held_r)
    else $error("accepted row not held");

  a_row_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rows_r <= ROW_CAP)
    else $error("row index past cap");

  a_top_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !held_r |-> (upper_r == '0))
    else $error("stale upper row at frame start");
endmodule
